// File: rtl/scma_pkg.sv
// ============================================================================
// Six-channel moving average: shared package
// Constants for the top level and the status type shared with the divider units.
// ============================================================================
package scma_pkg;

    // Number of averaged channels in one sample.
    localparam int NUM_CHANNELS = 6;

    // Width of the pass-through timestamp.
    localparam int TIME_BITS = 32;

    // Width of the window length register and its value after reset.
    localparam int CFG_BITS = 7;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd10;

    // Status that a divider reports to the sequencer.
    typedef struct packed {
        logic busy;     // A division is in progress.
        logic done;     // The quotient output holds the latest result.
    } div_status_t;

endpackage

// File: rtl/six_channel_moving_average_unit.sv
// ============================================================================
// Six-channel moving average unit
// Per-channel simple moving average of inertial samples with timestamp
// pass-through and a configurable window.
// ============================================================================
// Each accepted sample produces one result holding, for every channel, the
// mean of the most recent samples up to the configured window length (fewer
// while the window fills), truncated toward zero, plus the sample's timestamp.
// A window length of zero acts as one and values above MAX_WINDOW act as
// MAX_WINDOW; writing the window register also restarts the averaging. The
// oldest sample is read from the history RAM on acceptance; the running sums
// are then updated and the six bit-serial dividers started, which produce one
// quotient bit per cycle over the full sum width. The result is loaded into
// the output register once every divider is done and that register is free
// or being taken. A new sample is accepted in the cycle after the previous
// one has moved to the output register, even while that result still waits
// to be taken, so no sample is accepted while the previous one is averaged.
// No clearing pass is needed after reset.
// ============================================================================
module six_channel_moving_average_unit #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int DATA_BITS  =
        ((scma_pkg::NUM_CHANNELS * SAMPLE_BITS + scma_pkg::TIME_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: window length.
    input  logic                          cfg_wr_en,
    input  logic [scma_pkg::CFG_BITS-1:0] cfg_wr_data,
    // Sample stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: accel_x_sample, accel_y_sample, accel_z_sample,
    // rate_x_sample, rate_y_sample, rate_z_sample, time_tag, zero padding.
    input  logic [DATA_BITS-1:0]          s_tdata,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: accel_x_mean, accel_y_mean, accel_z_mean,
    // rate_x_mean, rate_y_mean, rate_z_mean, time_out, zero padding.
    output logic [DATA_BITS-1:0]          m_tdata
);

    localparam int NCH       = scma_pkg::NUM_CHANNELS;
    localparam int TBITS     = scma_pkg::TIME_BITS;
    localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_BITS = $clog2(MAX_WINDOW);
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
    localparam int ROW_BITS  = NCH * SAMPLE_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LAUNCH,
        ST_DIVIDE
    } state_t;

    state_t                       state_reg;
    logic [scma_pkg::CFG_BITS-1:0] window_reg;
    logic [CNT_BITS-1:0]          fill_reg;
    logic [SLOT_BITS-1:0]         slot_reg;
    logic [SLOT_BITS-1:0]         cur_slot_reg;
    logic                         full_reg;
    logic [ROW_BITS-1:0]          sample_reg;
    logic [TBITS-1:0]             time_reg;
    logic signed [SUM_BITS-1:0]   sum_reg [NCH];
    logic                         m_tvalid_reg;
    logic [DATA_BITS-1:0]         m_tdata_reg;

    logic [CNT_BITS-1:0]          win_eff;
    logic [SLOT_BITS-1:0]         slot_eff;
    logic                         full_eff;
    logic [CNT_BITS-1:0]          slot_inc;
    logic [SLOT_BITS-1:0]         slot_next;
    logic [CNT_BITS-1:0]          fill_next;
    logic signed [SUM_BITS-1:0]   sum_next [NCH];
    logic [ROW_BITS-1:0]          oldest_row;
    logic                         accept;
    logic                         div_start;
    logic                         out_load;
    logic [NCH-1:0]               done_vec;
    logic [NCH-1:0]               busy_vec;
    logic [DATA_BITS-1:0]         result_word;

    scma_pkg::div_status_t        div_status [NCH];
    logic [SAMPLE_BITS-1:0]       mean [NCH];

    // Effective window, clamped to the range one to MAX_WINDOW.
    always_comb begin
        if (window_reg == '0) begin
            win_eff = CNT_BITS'(1);
        end else if (32'(window_reg) > MAX_WINDOW) begin
            win_eff = CNT_BITS'(MAX_WINDOW);
        end else begin
            win_eff = CNT_BITS'(window_reg);
        end
    end

    // Ring position and fill state for the next sample.
    assign slot_eff  = (CNT_BITS'(slot_reg) >= win_eff) ? '0 : slot_reg;
    assign full_eff  = (fill_reg >= win_eff);
    assign slot_inc  = CNT_BITS'(cur_slot_reg) + 1'b1;
    assign slot_next = (slot_inc >= win_eff) ? '0 : SLOT_BITS'(slot_inc);
    assign fill_next = full_reg ? fill_reg : fill_reg + 1'b1;

    // Running sums: the oldest sample leaves once the window is full.
    always_comb begin
        logic signed [SAMPLE_BITS-1:0] new_s;
        logic signed [SAMPLE_BITS-1:0] old_s;
        for (int c = 0; c < NCH; c++) begin
            new_s       = sample_reg[c*SAMPLE_BITS +: SAMPLE_BITS];
            old_s       = oldest_row[c*SAMPLE_BITS +: SAMPLE_BITS];
            sum_next[c] = sum_reg[c] + SUM_BITS'(new_s)
                          - (full_reg ? SUM_BITS'(old_s) : SUM_BITS'(0));
        end
    end

    // Handshake and sequencing strobes.
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign div_start = (state_reg == ST_LAUNCH);
    assign out_load  = (state_reg == ST_DIVIDE) && (&done_vec)
                       && (!m_tvalid_reg || m_tready);

    // Sample history: the oldest row is read on acceptance, the new row
    // is written back in the following cycle.
    scma_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .clk     (aclk),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (cur_slot_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (slot_eff),
        .rd_data (oldest_row)
    );

    // One divider per channel, all started together.
    for (genvar c = 0; c < NCH; c++) begin : g_div
        scma_divider #(
            .SUM_BITS (SUM_BITS),
            .CNT_BITS (CNT_BITS),
            .QUO_BITS (SAMPLE_BITS)
        ) u_div (
            .clk      (aclk),
            .rstn     (aresetn),
            .start    (div_start),
            .dividend (sum_reg[c]),
            .divisor  (fill_reg),
            .status   (div_status[c]),
            .quotient (mean[c])
        );
        assign done_vec[c] = div_status[c].done;
        assign busy_vec[c] = div_status[c].busy;
    end

    // Result word: means, then the timestamp, then zero padding.
    always_comb begin
        result_word = '0;
        for (int c = 0; c < NCH; c++) begin
            result_word[c*SAMPLE_BITS +: SAMPLE_BITS] = mean[c];
        end
        result_word[ROW_BITS +: TBITS] = time_reg;
    end

    // Capture of the accepted sample.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg   <= s_tdata[ROW_BITS-1:0];
            time_reg     <= s_tdata[ROW_BITS +: TBITS];
            cur_slot_reg <= slot_eff;
            full_reg     <= full_eff;
        end
    end

    // Window register, ring pointer, fill count and running sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= scma_pkg::WINDOW_RESET;
            fill_reg   <= '0;
            slot_reg   <= '0;
            for (int c = 0; c < NCH; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
            fill_reg   <= '0;
            slot_reg   <= '0;
            for (int c = 0; c < NCH; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (state_reg == ST_UPDATE) begin
            fill_reg <= fill_next;
            slot_reg <= slot_next;
            for (int c = 0; c < NCH; c++) begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    // Sequencer and output register. A new result may replace the one
    // being taken in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= result_word;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    state_reg <= ST_LAUNCH;
                end
                ST_LAUNCH: begin
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The dividers are never busy while a new sample can be taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (busy_vec == '0))
        else $error("divider busy while idle");

    // An accepted sample always proceeds to the sum update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted sample skipped the update");

    // The fill count never exceeds the effective window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= win_eff)
        else $error("fill count beyond window");

    // The ring pointer stays inside the effective window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_BITS'(slot_reg) < win_eff)
        else $error("ring pointer outside window");

endmodule

// File: rtl/scma_ram.sv
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module scma_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

// File: rtl/scma_divider.sv
// ============================================================================
// Bit-serial signed divider
// Divides a signed running sum by an unsigned sample count, one quotient bit
// per cycle, and truncates the quotient toward zero.
// ============================================================================
module scma_divider #(
    parameter int SUM_BITS = 23,
    parameter int CNT_BITS = 7,
    parameter int QUO_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        start,
    input  logic signed [SUM_BITS-1:0]  dividend,
    input  logic [CNT_BITS-1:0]         divisor,
    output scma_pkg::div_status_t       status,
    output logic [QUO_BITS-1:0]         quotient
);

    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    logic [STEP_BITS-1:0] step_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [SUM_BITS-1:0]  quo_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]  div_reg;

    logic [SUM_BITS-1:0]  raw_dividend;
    logic [SUM_BITS-1:0]  magnitude;
    logic [CNT_BITS:0]    trial;
    logic [CNT_BITS:0]    diff;
    logic                 fits;
    logic [CNT_BITS-1:0]  rem_next;
    logic [SUM_BITS-1:0]  quo_next;
    logic [SUM_BITS-1:0]  signed_quo;

    // Magnitude of the dividend; the most negative sum still fits unsigned.
    assign raw_dividend = dividend;
    assign magnitude    = raw_dividend[SUM_BITS-1] ? (~raw_dividend + 1'b1) : raw_dividend;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial    = {rem_reg, quo_reg[SUM_BITS-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
        quo_next = {quo_reg[SUM_BITS-2:0], fits};
    end

    // Step counter and completion flag.
    always_ff @(posedge clk) begin
        if (!rstn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            step_reg <= STEP_BITS'(SUM_BITS);
            done_reg <= 1'b0;
        end else if (step_reg != '0) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1)) begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk) begin
        if (start) begin
            neg_reg <= raw_dividend[SUM_BITS-1];
            quo_reg <= magnitude;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (step_reg != '0) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Restore the sign; the mean always fits the sample width.
    assign signed_quo  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient    = signed_quo[QUO_BITS-1:0];
    assign status.busy = (step_reg != '0);
    assign status.done = done_reg;

endmodule
